// ===== hw/rtl/rrs_pkg.sv =====
// ============================================================================
// rrs_pkg
// Shared types and opcode constants of the rip-relative reference scanner.
// ============================================================================
package rrs_pkg;

    localparam int ADDR_W = 64;
    localparam int BYTE_W = 8;
    localparam int CAND_BYTES = 8;
    localparam int WIN_BYTES = CAND_BYTES - 1;
    localparam int FILL_W = 3;

    // configuration register indexes
    localparam logic [1:0] REG_TARGET_ADDRESS = 2'd0;
    localparam logic [1:0] REG_SECTION_BASE = 2'd1;

    // opcode bytes
    localparam logic [7:0] OP_CALL = 8'hE8;
    localparam logic [7:0] OP_JMP = 8'hE9;
    localparam logic [7:0] PFX_REX_W = 8'h48;
    localparam logic [7:0] OP_MOV_LOAD = 8'h8B;
    localparam logic [7:0] OP_LEA = 8'h8D;
    localparam logic [7:0] OP_MOV_STORE = 8'h89;
    localparam logic [7:0] MODRM_MASK = 8'hC7;
    localparam logic [7:0] MODRM_RIP = 8'h05;

    localparam logic [ADDR_W-1:0] LEN_BRANCH = 64'd5;
    localparam logic [ADDR_W-1:0] LEN_MODRM = 64'd7;

    // one eight-byte candidate, byte 0 is the oldest
    typedef struct packed {
        logic [CAND_BYTES-1:0][BYTE_W-1:0] bytes;
        logic                              check;
    } cand_t;

endpackage

// ===== hw/rtl/rip_relative_reference_scanner.sv =====
// ============================================================================
// rip_relative_reference_scanner
// Scans a code byte stream for rip-relative calls, jumps, loads, leas and
// stores that reference target_address and reports the instruction address.
// ============================================================================
// path: a hit leaves through the candidate register, then the result
//   register, after the transfer of the candidate's eighth byte
// throughput: one byte per cycle; the input stalls only while a hit waits
//   in the candidate register behind a stalled result register
// reset: window, fill count, section offset, pipeline valids and both
//   configuration registers clear asynchronously on rst_n low
module rip_relative_reference_scanner #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // byte input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  code_byte,
    input  logic        section_end,
    // hit output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hit_address
);

    logic [rrs_pkg::ADDR_W-1:0] target_address_reg;
    logic [rrs_pkg::ADDR_W-1:0] section_base_reg;
    logic [rrs_pkg::ADDR_W-1:0] hit_address_reg, hit_address_next;
    logic                       out_valid_reg, out_valid_next;

    logic                       in_accept;
    logic                       s1_valid;
    logic                       s1_advance;
    rrs_pkg::cand_t             s1_cand;
    logic [OFFSET_BITS-1:0]     s1_off;
    logic                       s1_hit;
    logic [rrs_pkg::ADDR_W-1:0] s1_address;
    logic                       out_free;

    // configuration registers; the user writes them only while the scanner is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_address_reg <= '0;
            section_base_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rrs_pkg::REG_TARGET_ADDRESS: target_address_reg <= cfg_data;
                rrs_pkg::REG_SECTION_BASE:   section_base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // result register is free when empty or its transfer completes now
    assign out_free = !out_valid_reg || !out_stall;
    // a candidate without a hit never waits for the result register
    assign s1_advance = s1_valid && (!s1_hit || out_free);
    assign in_stall = s1_valid && !s1_advance;
    assign in_accept = in_valid && !in_stall;

    // window shift and candidate capture
    rrs_window #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .code_byte  (code_byte),
        .section_end(section_end),
        .advance    (s1_advance),
        .cand_valid (s1_valid),
        .cand       (s1_cand),
        .cand_off   (s1_off)
    );

    // pattern decode plus address compare
    rrs_match #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_match (
        .cand          (s1_cand),
        .cand_off      (s1_off),
        .section_base  (section_base_reg),
        .target_address(target_address_reg),
        .hit           (s1_hit),
        .insn_address  (s1_address)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        hit_address_next = hit_address_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid && s1_hit;
            hit_address_next = s1_address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_address_reg <= hit_address_next;
    end

    assign out_valid = out_valid_reg;
    assign hit_address = hit_address_reg;

    // input only backs up behind a pending candidate
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid && s1_hit && out_valid_reg && out_stall))
        else $error("input stall without a blocked hit");

    // a new result only comes from a hit candidate
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid && s1_hit))
        else $error("result appeared without a hit");

    // a completed result transfer with nothing behind it empties the register
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !s1_valid) |=> !out_valid)
        else $error("result repeated after its transfer");

endmodule

// ===== hw/rtl/rrs_window.sv =====
// ============================================================================
// rrs_window
// Sliding byte window, section offset and the candidate register.
// ============================================================================
module rrs_window #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             code_byte,
    input  logic                   section_end,
    input  logic                   advance,
    output logic                   cand_valid,
    output rrs_pkg::cand_t         cand,
    output logic [OFFSET_BITS-1:0] cand_off
);

    logic [rrs_pkg::WIN_BYTES-1:0][rrs_pkg::BYTE_W-1:0] win_reg, win_next;
    logic [rrs_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [OFFSET_BITS-1:0]     off_reg, off_next;
    logic                       cand_valid_reg, cand_valid_next;
    rrs_pkg::cand_t             cand_reg, cand_next;
    logic [OFFSET_BITS-1:0]     cand_off_reg, cand_off_next;
    logic                       full;

    assign full = (fill_reg == rrs_pkg::FILL_W'(rrs_pkg::WIN_BYTES));

    always_comb
    begin
        win_next = win_reg;
        fill_next = fill_reg;
        off_next = off_reg;
        cand_next = cand_reg;
        cand_off_next = cand_off_reg;
        cand_valid_next = cand_valid_reg;
        if (advance)
        begin
            cand_valid_next = 1'b0;
        end
        if (accept)
        begin
            cand_valid_next = 1'b1;
            cand_next.bytes = {code_byte, win_reg};
            cand_next.check = full;
            cand_off_next = off_reg - OFFSET_BITS'(rrs_pkg::WIN_BYTES);
            if (full)
            begin
                win_next = {code_byte, win_reg[rrs_pkg::WIN_BYTES-1:1]};
            end
            else
            begin
                for (int i = 0; i < rrs_pkg::WIN_BYTES; i++)
                begin
                    if (fill_reg == rrs_pkg::FILL_W'(i))
                    begin
                        win_next[i] = code_byte;
                    end
                end
                fill_next = fill_reg + rrs_pkg::FILL_W'(1);
            end
            off_next = off_reg + OFFSET_BITS'(1);
            // restart at the section boundary
            if (section_end)
            begin
                win_next = '0;
                fill_next = '0;
                off_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            fill_reg <= '0;
            off_reg <= '0;
            cand_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg <= win_next;
            fill_reg <= fill_next;
            off_reg <= off_next;
            cand_valid_reg <= cand_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        cand_off_reg <= cand_off_next;
    end

    assign cand_valid = cand_valid_reg;
    assign cand = cand_reg;
    assign cand_off = cand_off_reg;

endmodule

// ===== hw/rtl/rrs_match.sv =====
// ============================================================================
// rrs_match
// Decodes one candidate and compares its reference target with the sought
// address.
// ============================================================================
module rrs_match #(
    parameter int OFFSET_BITS = 32
) (
    input  rrs_pkg::cand_t                 cand,
    input  logic [OFFSET_BITS-1:0]         cand_off,
    input  logic [rrs_pkg::ADDR_W-1:0]     section_base,
    input  logic [rrs_pkg::ADDR_W-1:0]     target_address,
    output logic                           hit,
    output logic [rrs_pkg::ADDR_W-1:0]     insn_address
);

    logic                          is_branch;
    logic                          is_modrm;
    logic [31:0]                   disp;
    logic [rrs_pkg::ADDR_W-1:0]    len;
    logic [rrs_pkg::ADDR_W-1:0]    ref_address;

    always_comb
    begin
        is_branch = (cand.bytes[0] == rrs_pkg::OP_CALL) ||
                    (cand.bytes[0] == rrs_pkg::OP_JMP);
        is_modrm = (cand.bytes[0] == rrs_pkg::PFX_REX_W) &&
                   ((cand.bytes[1] == rrs_pkg::OP_MOV_LOAD) ||
                    (cand.bytes[1] == rrs_pkg::OP_LEA) ||
                    (cand.bytes[1] == rrs_pkg::OP_MOV_STORE)) &&
                   ((cand.bytes[2] & rrs_pkg::MODRM_MASK) == rrs_pkg::MODRM_RIP);
        if (is_branch)
        begin
            disp = {cand.bytes[4], cand.bytes[3], cand.bytes[2], cand.bytes[1]};
            len = rrs_pkg::LEN_BRANCH;
        end
        else
        begin
            disp = {cand.bytes[6], cand.bytes[5], cand.bytes[4], cand.bytes[3]};
            len = rrs_pkg::LEN_MODRM;
        end
        insn_address = section_base +
                       {{(rrs_pkg::ADDR_W-OFFSET_BITS){1'b0}}, cand_off};
        ref_address = insn_address + len + {{32{disp[31]}}, disp};
        hit = cand.check && (is_branch || is_modrm) &&
              (ref_address == target_address);
    end

endmodule

// ===== tb/rip_relative_reference_scanner_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rip_relative_reference_scanner_checker
// Watches the byte and hit channels and the register port. It predicts the
// hit addresses of the scanner and compares every hit transfer with the
// oldest one still awaited.
// ============================================================================
module rip_relative_reference_scanner_checker #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  code_byte,
    input  logic        section_end,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] hit_address,
    output int          fail_count,
    output int          pending_hits
);

    logic [rrs_pkg::ADDR_W-1:0] target_reg;
    logic [rrs_pkg::ADDR_W-1:0] base_reg;
    logic [rrs_pkg::BYTE_W-1:0] window [rrs_pkg::WIN_BYTES];
    int                         fill;
    logic [OFFSET_BITS-1:0]     offset;
    logic [rrs_pkg::ADDR_W-1:0] hit_addr_q [$];
    logic [rrs_pkg::ADDR_W-1:0] want;
    int                         fails;

    function automatic logic [rrs_pkg::ADDR_W-1:0] sext_disp(input logic [31:0] d);
        return {{32{d[31]}}, d};
    endfunction

    // candidate byte 0 is the oldest
    function automatic logic refers_to_target(
        input logic [rrs_pkg::CAND_BYTES-1:0][rrs_pkg::BYTE_W-1:0] c,
        input logic [rrs_pkg::ADDR_W-1:0]                          va,
        input logic [rrs_pkg::ADDR_W-1:0]                          tgt
    );
        if (c[0] == rrs_pkg::OP_CALL || c[0] == rrs_pkg::OP_JMP)
            return (va + rrs_pkg::LEN_BRANCH +
                    sext_disp({c[4], c[3], c[2], c[1]})) == tgt;
        if (c[0] == rrs_pkg::PFX_REX_W &&
            (c[1] == rrs_pkg::OP_MOV_LOAD || c[1] == rrs_pkg::OP_LEA ||
             c[1] == rrs_pkg::OP_MOV_STORE) &&
            (c[2] & rrs_pkg::MODRM_MASK) == rrs_pkg::MODRM_RIP)
            return (va + rrs_pkg::LEN_MODRM +
                    sext_disp({c[6], c[5], c[4], c[3]})) == tgt;
        return 1'b0;
    endfunction

    task automatic clear_window();
        for (int i = 0; i < rrs_pkg::WIN_BYTES; i++)
            window[i] = '0;
        fill = 0;
        offset = '0;
    endtask

    task automatic scan_byte(input logic [rrs_pkg::BYTE_W-1:0] b, input logic last);
        logic [rrs_pkg::CAND_BYTES-1:0][rrs_pkg::BYTE_W-1:0] c;
        logic [OFFSET_BITS-1:0]                              cand_off;
        logic [rrs_pkg::ADDR_W-1:0]                          va;
        if (fill >= rrs_pkg::WIN_BYTES)
        begin
            cand_off = offset - OFFSET_BITS'(rrs_pkg::WIN_BYTES);
            va = base_reg + rrs_pkg::ADDR_W'(cand_off);
            for (int i = 0; i < rrs_pkg::WIN_BYTES; i++)
                c[i] = window[i];
            c[rrs_pkg::WIN_BYTES] = b;
            if (refers_to_target(c, va, target_reg))
                hit_addr_q = {hit_addr_q, va};
            for (int i = 0; i < rrs_pkg::WIN_BYTES - 1; i++)
                window[i] = window[i + 1];
            window[rrs_pkg::WIN_BYTES - 1] = b;
        end
        else
        begin
            window[fill] = b;
            fill++;
        end
        offset = offset + OFFSET_BITS'(1);
        if (last)
            clear_window();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("[%0t] mismatch %s: got %h, expected %h", $time, what, got, exp_val);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg = '0;
            base_reg = '0;
            clear_window();
            hit_addr_q.delete();
            fails = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == rrs_pkg::REG_TARGET_ADDRESS)
                    target_reg = cfg_data;
                else if (cfg_index == rrs_pkg::REG_SECTION_BASE)
                    base_reg = cfg_data;
            end
            // a hit leaving now was predicted before this edge
            if (out_valid && !out_stall)
            begin
                if (hit_addr_q.size() == 0)
                    report_mismatch("hit with none awaited", hit_address, '0);
                else
                begin
                    want = hit_addr_q.pop_front();
                    if (hit_address !== want)
                        report_mismatch("hit_address", hit_address, want);
                end
            end
            if (in_valid && !in_stall)
                scan_byte(code_byte, section_end);
        end
        fail_count <= fails;
        pending_hits <= hit_addr_q.size();
    end

endmodule

// ===== tb/rip_relative_reference_scanner_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rip_relative_reference_scanner_tb
// Feeds code sections built from call, jump, load, lea and store encodings
// aimed at the target, near misses and noise, under random idling on both
// channels and across several register settings; a checker beside the
// scanner predicts and compares every hit.
// ============================================================================
module rip_relative_reference_scanner_tb;

    localparam int OFFSET_BITS = 32;
    localparam int PHASES = 12;
    localparam int PHASE_BYTES = 88;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT = 5000;
    localparam longint LIMIT_NS = 4_000_000;

    // indexes with no register behind them
    localparam logic [1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [1:0] REG_UNUSED_3 = 2'd3;

    typedef enum logic [1:0] {
        INSN_NOISE,
        INSN_HIT,
        INSN_NEAR_MISS
    } insn_kind_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  code_byte;
    logic        section_end;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] hit_address;
    int          fail_count;
    int          pending_hits;

    // generator view of the registers and of the section being sent
    logic [63:0] cur_target;
    logic [63:0] cur_base;
    logic [63:0] sec_off;
    int          sec_left;
    int          bytes_sent;
    int          gap_odds;
    bit          quiet;

    rip_relative_reference_scanner #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_byte   (code_byte),
        .section_end (section_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit_address (hit_address)
    );

    rip_relative_reference_scanner_checker #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code_byte    (code_byte),
        .section_end  (section_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit_address  (hit_address),
        .fail_count   (fail_count),
        .pending_hits (pending_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop well past the slowest correct run
    initial
    begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // receiver side: runs of open cycles broken by stall bursts, none when quiet
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (!quiet)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // one register write; the enable is dropped again before the task returns
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == rrs_pkg::REG_TARGET_ADDRESS)
            cur_target = val;
        else if (idx == rrs_pkg::REG_SECTION_BASE)
            cur_base = val;
    endtask

    // hold off the sender until every awaited hit has left, then let the
    // pipeline settle so a write cannot land on a byte still in flight
    task automatic drain_hits();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (pending_hits != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one byte transfer; section_end rides on the last byte of the section
    task automatic send_byte(input logic [7:0] b);
        in_valid <= 1'b1;
        code_byte <= b;
        section_end <= (sec_left == 1);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        sec_left--;
        sec_off = (sec_left == 0) ? 64'd0 : sec_off + 64'd1;
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic start_section(input int len);
        sec_left = len;
        sec_off = 64'd0;
        gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 6;
    endtask

    // builds one encoding at the current section offset and sends what
    // fits before the section ends; hits aim the displacement at the target
    task automatic emit_insn(input insn_kind_t kind, input logic [7:0] op_in);
        logic [7:0]  ib [$];
        logic [7:0]  op;
        logic [7:0]  pfx;
        logic [7:0]  modrm;
        logic [63:0] disp;
        logic        branch;
        op = op_in;
        pfx = rrs_pkg::PFX_REX_W;
        branch = (op == rrs_pkg::OP_CALL || op == rrs_pkg::OP_JMP);
        modrm = {2'b00, 3'($urandom_range(0, 7)), 3'b101};
        if (kind == INSN_NOISE)
        begin
            // noise leans toward opcode bytes to build partial patterns
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 5))
                    0: ib = {ib, rrs_pkg::OP_CALL};
                    1: ib = {ib, rrs_pkg::PFX_REX_W};
                    2: ib = {ib, rrs_pkg::OP_LEA};
                    3: ib = {ib, rrs_pkg::MODRM_RIP};
                    default: ib = {ib, 8'($urandom)};
                endcase
            end
        end
        else
        begin
            disp = cur_target - (cur_base + sec_off +
                                 (branch ? rrs_pkg::LEN_BRANCH : rrs_pkg::LEN_MODRM));
            // out of reach of a 32-bit displacement: plain random content
            if (disp[63:31] != {33{disp[31]}})
                disp = {$urandom, $urandom};
            if (kind == INSN_NEAR_MISS)
            begin
                case ($urandom_range(0, branch ? 1 : 4))
                    0: disp[0] = ~disp[0];
                    1: op = op ^ 8'h10;
                    2: modrm[7:6] = 2'($urandom_range(1, 3));
                    3: modrm[2:0] = 3'b100;
                    default: pfx = 8'h49;
                endcase
            end
            if (!branch)
                ib = {ib, pfx};
            ib = {ib, op};
            if (!branch)
                ib = {ib, modrm};
            for (int k = 0; k < 4; k++)
                ib = {ib, disp[8*k +: 8]};
        end
        foreach (ib[i])
            if (sec_left > 0)
                send_byte(ib[i]);
    endtask

    initial
    begin
        int          ph;
        int          goal;
        int          r;
        logic [7:0]  op;
        insn_kind_t  kind;
        logic [31:0] rr;

        // every input known from time zero
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = rrs_pkg::REG_TARGET_ADDRESS;
        cfg_data = '0;
        in_valid = 1'b0;
        code_byte = '0;
        section_end = 1'b0;
        quiet = 1'b0;
        cur_target = '0;
        cur_base = '0;
        sec_off = '0;
        sec_left = 0;
        bytes_sent = 0;
        gap_odds = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: writes to unused indexes must leave both registers alone
        write_reg(rrs_pkg::REG_TARGET_ADDRESS, 64'h0000_0000_0000_2000);
        write_reg(rrs_pkg::REG_SECTION_BASE, 64'h0000_0000_0000_1000);
        write_reg(REG_UNUSED_2, '1);
        write_reg(REG_UNUSED_3, 64'h5555_5555_5555_5555);

        // call and load hits, both with a full window behind them
        start_section(13);
        emit_insn(INSN_HIT, rrs_pkg::OP_CALL);
        emit_insn(INSN_HIT, rrs_pkg::OP_MOV_LOAD);
        send_byte(8'h00);
        // jump hit, then a lea that sits in the section tail and never counts
        start_section(12);
        emit_insn(INSN_HIT, rrs_pkg::OP_JMP);
        emit_insn(INSN_HIT, rrs_pkg::OP_LEA);
        // store hit checked on the very first full window
        start_section(8);
        emit_insn(INSN_HIT, rrs_pkg::OP_MOV_STORE);
        send_byte(8'hFF);

        // random phases, each with its own register setting
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_hits();
            quiet = (ph >= PHASES - 2);
            case (ph)
                0:
                begin
                    // references wrap below zero
                    write_reg(rrs_pkg::REG_SECTION_BASE, '0);
                    write_reg(rrs_pkg::REG_TARGET_ADDRESS, '1);
                end
                1:
                begin
                    // references wrap past the top of the address space
                    write_reg(rrs_pkg::REG_SECTION_BASE, 64'hFFFF_FFFF_FFFF_FFC0);
                    write_reg(rrs_pkg::REG_TARGET_ADDRESS, 64'h0000_0000_0000_0100);
                end
                2:
                begin
                    write_reg(rrs_pkg::REG_SECTION_BASE, '1);
                    write_reg(rrs_pkg::REG_TARGET_ADDRESS, '0);
                end
                3:
                begin
                    write_reg(rrs_pkg::REG_SECTION_BASE, '0);
                    write_reg(rrs_pkg::REG_TARGET_ADDRESS, '0);
                end
                5:
                begin
                    // unrelated target, hits only by chance
                    write_reg(rrs_pkg::REG_SECTION_BASE, {$urandom, $urandom});
                    write_reg(rrs_pkg::REG_TARGET_ADDRESS, {$urandom, $urandom});
                end
                default:
                begin
                    rr = $urandom;
                    write_reg(rrs_pkg::REG_SECTION_BASE, {$urandom, $urandom});
                    write_reg(rrs_pkg::REG_TARGET_ADDRESS, cur_base + {{32{rr[31]}}, rr});
                end
            endcase

            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal)
            begin
                // mostly full sections, some too short for any candidate
                start_section(($urandom_range(0, 5) == 0) ? $urandom_range(1, 7)
                                                          : $urandom_range(8, 64));
                while (sec_left > 0)
                begin
                    // a base change mid-section applies to later candidates
                    if ($urandom_range(0, 149) == 0)
                    begin
                        drain_hits();
                        write_reg(rrs_pkg::REG_SECTION_BASE, {$urandom, $urandom});
                    end
                    r = $urandom_range(0, 9);
                    kind = (r < 4) ? INSN_NOISE : (r < 8) ? INSN_HIT : INSN_NEAR_MISS;
                    case ($urandom_range(0, 4))
                        0: op = rrs_pkg::OP_CALL;
                        1: op = rrs_pkg::OP_JMP;
                        2: op = rrs_pkg::OP_MOV_LOAD;
                        3: op = rrs_pkg::OP_LEA;
                        default: op = rrs_pkg::OP_MOV_STORE;
                    endcase
                    emit_insn(kind, op);
                end
            end
        end

        // wait out every awaited hit, then the pipeline latency
        drain_hits();
        if (pending_hits != 0)
            $display("%0d hits never arrived", pending_hits);
        if (fail_count == 0 && pending_hits == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
